// ===== rtl/core/slbs_pkg.sv =====
// ----------------------------------------------------------------------------
// slbs_pkg: shared definitions for the status LED blink sequencer
// Register indexes, event codes, field widths and reset values.
// ----------------------------------------------------------------------------
package slbs_pkg;

   // Pattern geometry and field widths
   localparam int SLOT_COUNT   = 6;
   localparam int SLOT_IDX_W   = 3;
   localparam int SLOT_TICKS_W = 16;
   localparam int IDLE_W       = 24;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 24;

   // Register reset values
   localparam logic [SLOT_TICKS_W-1:0] SLOT_SHORT_RESET = 16'd5000;
   localparam logic [SLOT_TICKS_W-1:0] SLOT_LONG_RESET  = 16'd45000;
   localparam logic [IDLE_W-1:0]       IDLE_TIMEOUT_RESET = 24'd50000;

   // Last slot of the pattern
   localparam logic [SLOT_IDX_W-1:0] SLOT_LAST = SLOT_IDX_W'(SLOT_COUNT - 1);

   // Register indexes on the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLOT0        = 3'd0,
      CSR_SLOT1        = 3'd1,
      CSR_SLOT2        = 3'd2,
      CSR_SLOT3        = 3'd3,
      CSR_SLOT4        = 3'd4,
      CSR_SLOT5        = 3'd5,
      CSR_IDLE_TIMEOUT = 3'd6
   } csr_idx_type;

   // Event kinds
   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_FRAME = 1'b1
   } op_type;

   // Configuration as seen by the sequencer core
   typedef struct packed {
      logic [SLOT_COUNT-1:0][SLOT_TICKS_W-1:0] slot_ticks;
      logic [IDLE_W-1:0]                       idle_timeout;
   } cfg_type;

endpackage

// ===== rtl/core/slbs_csr.sv =====
// ----------------------------------------------------------------------------
// slbs_csr: configuration registers
// Six slot durations and the idle timeout, written over the csr channel.
// ----------------------------------------------------------------------------
module slbs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [slbs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [slbs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output slbs_pkg::cfg_type                  cfg
);

   logic [slbs_pkg::SLOT_COUNT-1:0][slbs_pkg::SLOT_TICKS_W-1:0] slot_ticks_ff;
   logic [slbs_pkg::IDLE_W-1:0]                                 idle_timeout_ff;
   logic                                                        wr_en;

   // Writes are always accepted; csr_ready is tied high
   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;

   // Register file; writes to unused indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ticks_ff[0] <= slbs_pkg::SLOT_SHORT_RESET;
         slot_ticks_ff[1] <= slbs_pkg::SLOT_SHORT_RESET;
         slot_ticks_ff[2] <= slbs_pkg::SLOT_SHORT_RESET;
         slot_ticks_ff[3] <= slbs_pkg::SLOT_SHORT_RESET;
         slot_ticks_ff[4] <= slbs_pkg::SLOT_SHORT_RESET;
         slot_ticks_ff[5] <= slbs_pkg::SLOT_LONG_RESET;
         idle_timeout_ff  <= slbs_pkg::IDLE_TIMEOUT_RESET;
      end else if (wr_en) begin
         case (slbs_pkg::csr_idx_type'(csr_index))
            slbs_pkg::CSR_SLOT0: begin
               slot_ticks_ff[0] <= csr_wdata[slbs_pkg::SLOT_TICKS_W-1:0];
            end
            slbs_pkg::CSR_SLOT1: begin
               slot_ticks_ff[1] <= csr_wdata[slbs_pkg::SLOT_TICKS_W-1:0];
            end
            slbs_pkg::CSR_SLOT2: begin
               slot_ticks_ff[2] <= csr_wdata[slbs_pkg::SLOT_TICKS_W-1:0];
            end
            slbs_pkg::CSR_SLOT3: begin
               slot_ticks_ff[3] <= csr_wdata[slbs_pkg::SLOT_TICKS_W-1:0];
            end
            slbs_pkg::CSR_SLOT4: begin
               slot_ticks_ff[4] <= csr_wdata[slbs_pkg::SLOT_TICKS_W-1:0];
            end
            slbs_pkg::CSR_SLOT5: begin
               slot_ticks_ff[5] <= csr_wdata[slbs_pkg::SLOT_TICKS_W-1:0];
            end
            slbs_pkg::CSR_IDLE_TIMEOUT: begin
               idle_timeout_ff <= csr_wdata[slbs_pkg::IDLE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.slot_ticks   = slot_ticks_ff;
   assign cfg.idle_timeout = idle_timeout_ff;

endmodule

// ===== rtl/core/slbs_core.sv =====
// ----------------------------------------------------------------------------
// slbs_core: sequencer state and per-event update
// Holds LED level, pattern position and idle count; one event per cycle while take is high.
// ----------------------------------------------------------------------------
module slbs_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic              operation,
   input  logic              has_error,
   input  slbs_pkg::cfg_type cfg,
   output logic              led_in
);

   logic                              led_level_ff;
   logic [slbs_pkg::SLOT_IDX_W-1:0]   slot_index_ff, slot_index_in;
   logic [slbs_pkg::SLOT_TICKS_W-1:0] slot_elapsed_ff, slot_elapsed_in;
   logic [slbs_pkg::IDLE_W-1:0]       idle_ticks_ff, idle_ticks_in;

   logic [slbs_pkg::SLOT_IDX_W-1:0]   slot_cur;
   logic [slbs_pkg::SLOT_IDX_W-1:0]   slot_adv;
   logic [slbs_pkg::SLOT_TICKS_W-1:0] elapsed_inc;
   logic [slbs_pkg::SLOT_TICKS_W-1:0] dur_cur;
   logic                              next_is_zero;
   logic [slbs_pkg::IDLE_W:0]         idle_inc;

   // Pattern datapath
   assign slot_cur    = (slot_index_ff > slbs_pkg::SLOT_LAST) ? '0 : slot_index_ff;
   assign slot_adv    = slot_cur + 3'd1;
   assign dur_cur     = cfg.slot_ticks[slot_cur];
   assign elapsed_inc = slot_elapsed_ff + 16'd1;
   assign next_is_zero = (slot_cur == slbs_pkg::SLOT_LAST) ? 1'b1
                       : (cfg.slot_ticks[slot_adv] == '0);

   // Idle counter with one spare bit for the compare
   assign idle_inc = {1'b0, idle_ticks_ff} + 25'd1;

   // Next state for the accepted event
   always_comb begin
      led_in          = led_level_ff;
      slot_index_in   = slot_index_ff;
      slot_elapsed_in = slot_elapsed_ff;
      idle_ticks_in   = idle_ticks_ff;
      if (slbs_pkg::op_type'(operation) == slbs_pkg::OP_FRAME) begin
         led_in        = ~led_level_ff;
         idle_ticks_in = '0;
      end else if (has_error) begin
         led_in = ~slot_cur[0];
         if (elapsed_inc >= dur_cur) begin
            slot_elapsed_in = '0;
            slot_index_in   = next_is_zero ? '0 : slot_adv;
         end else begin
            slot_elapsed_in = elapsed_inc;
            slot_index_in   = slot_cur;
         end
      end else begin
         slot_index_in   = '0;
         slot_elapsed_in = '0;
         if (idle_inc > {1'b0, cfg.idle_timeout}) begin
            led_in        = 1'b0;
            idle_ticks_in = cfg.idle_timeout;
         end else begin
            idle_ticks_in = idle_inc[slbs_pkg::IDLE_W-1:0];
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         led_level_ff    <= 1'b0;
         slot_index_ff   <= '0;
         slot_elapsed_ff <= '0;
         idle_ticks_ff   <= '0;
      end else if (take) begin
         led_level_ff    <= led_in;
         slot_index_ff   <= slot_index_in;
         slot_elapsed_ff <= slot_elapsed_in;
         idle_ticks_ff   <= idle_ticks_in;
      end
   end

   // Pattern position never leaves the six slots
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_index_ff <= slbs_pkg::SLOT_LAST)
      else $error("slot index out of range");

   // A frame toggles the LED and clears the idle count
   a_frame_update: assert property (@(posedge clock) disable iff (reset)
      (take && operation) |=>
         (idle_ticks_ff == '0) && (led_level_ff != $past(led_level_ff)))
      else $error("frame did not toggle LED or clear idle count");

endmodule

// ===== rtl/core/slbs_skid.sv =====
// ----------------------------------------------------------------------------
// slbs_skid: result register with skid stage
// Two-entry output buffer so an event is taken while a result waits.
// ----------------------------------------------------------------------------
module slbs_skid (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic push_led,
   output logic full,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_led
);

   logic out_valid_ff;
   logic out_led_ff;
   logic skid_valid_ff;
   logic skid_led_ff;
   logic out_free;

   // Output slot empties this cycle or is already empty
   assign out_free = ~out_valid_ff | ~rsp_stall;

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff | push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_led_ff <= skid_valid_ff ? skid_led_ff : push_led;
      end else if (push) begin
         skid_led_ff <= push_led;
      end
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_led   = out_led_ff;

   // Skid entry only holds data behind a stalled output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without output entry");

   // No transfer arrives while the buffer is full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> ~skid_valid_ff)
      else $error("push into full output buffer");

   // Draining the skid stage moves its result to the output
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_free) |=> (out_valid_ff && out_led_ff == $past(skid_led_ff)))
      else $error("skid result lost on drain");

endmodule

// ===== rtl/core/status_led_blink_sequencer.sv =====
// ----------------------------------------------------------------------------
// status_led_blink_sequencer: status LED driver
// Frame events toggle the LED, error ticks play a six-slot blink pattern,
// normal ticks count idle time and force the LED off past the timeout.
// ----------------------------------------------------------------------------
// One event is accepted per clock while req_stall is low; each yields one
// LED level on the rsp channel, registered in the output buffer. The state
// update is combinational counter logic, and a two-entry output buffer lets
// req keep flowing while a result waits; req_stall rises only when both
// entries are held. Configuration writes are always accepted (csr_ready is
// always high) and must only be issued while no event is in flight.
// ----------------------------------------------------------------------------
module status_led_blink_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   // Event input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_operation,
   input  logic                            req_has_error,
   // LED result
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_led,
   // Configuration
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [slbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [slbs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   slbs_pkg::cfg_type cfg;
   logic              take;
   logic              led_in;
   logic              buf_full;

   // Input transfer
   assign req_stall = buf_full;
   assign take      = req_valid & ~req_stall;

   slbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   slbs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .operation (req_operation),
      .has_error (req_has_error),
      .cfg       (cfg),
      .led_in    (led_in)
   );

   slbs_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_led  (led_in),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_led   (rsp_led)
   );

endmodule
